// File: rtl/flash_write_chunk_planner_unit_assert.svh
`ifndef FLASH_WRITE_CHUNK_PLANNER_UNIT_ASSERT_SVH
`define FLASH_WRITE_CHUNK_PLANNER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define FWCP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FWCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/fwcp_pkg.sv
package fwcp_pkg;

	localparam int ADDR_W     = 24;
	localparam int CNT_W      = 8;
	localparam int OFF_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int BLOCK_SIZE = 128;
	localparam int MAX_COUNT  = 128;
	localparam int WORD_BYTES = 4;
	localparam int BLK_LG     = $clog2(BLOCK_SIZE);
	localparam int WORD_LG    = $clog2(WORD_BYTES);
	localparam int STEP_W     = ($clog2(BLOCK_SIZE + 1) > CNT_W) ?
		$clog2(BLOCK_SIZE + 1) : CNT_W;
	localparam int ALU_W      = ADDR_W + 2;

	localparam logic [ADDR_W-1:0] PROG_START_RST = 24'h008000;
	localparam logic [ADDR_W-1:0] PROG_END_RST   = 24'h010000;
	localparam logic [ADDR_W-1:0] DATA_START_RST = 24'h004000;
	localparam logic [ADDR_W-1:0] DATA_END_RST   = 24'h0047FF;

	localparam logic [CFG_IDX_W-1:0] CFG_PROG_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROG_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_END   = 2'd3;

	localparam logic MEM_PROG = 1'b0;
	localparam logic MEM_DATA = 1'b1;

	typedef enum logic [2:0] {
		CK_BYTE   = 3'd0,
		CK_WORD   = 3'd1,
		CK_BLOCK  = 3'd2,
		CK_REJECT = 3'd3,
		CK_EMPTY  = 3'd4
	} cmd_kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LAST,
		S_PLO,
		S_PHI,
		S_DLO,
		S_DHI,
		S_EMIT,
		S_REL,
		S_BLK,
		S_SINGLE
	} state_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              mem;
		logic [ADDR_W-1:0] target;
		logic [OFF_W-1:0]  off;
		logic              last;
	} result_t;

endpackage

// File: rtl/flash_write_chunk_planner_unit.sv
// channel  | dir | tdata (low bit up)                         | tuser / tlast
// s_axis   | in  | start_address[23:0], byte_count[31:24]      | -
// m_axis   | out | target[23:0], payload_offset[30:24], pad    | kind[2:0], mem[3] / last
// cfg      | in  | cfg_we, cfg_index, cfg_wdata[23:0]          | -
//
// One request in S_IDLE only; range checks on the shared 26-bit add/subtract
// unit run S_LAST, S_PLO, S_PHI (program window), then on a miss S_DLO, S_DHI
// (EEPROM window); then one command per cycle unless m_axis stalls; a block
// command goes via S_REL and S_BLK (block number via the unit). Worst case 35 commands.
// Single result via S_SINGLE after the take (empty), S_LAST (count too large) or S_DHI (out of range).
// Registered output; an m_axis stall holds the FSM; arst_n clears control and window registers only.
`include "flash_write_chunk_planner_unit_assert.svh"

module flash_write_chunk_planner_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,  // start_address, byte_count
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [31:0]                       m_axis_tdata,  // target, payload_offset, 0
	output logic [3:0]                        m_axis_tuser,  // command_kind, memory_kind
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [fwcp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fwcp_pkg::ADDR_W-1:0]       cfg_wdata
);
	import fwcp_pkg::*;

	logic [ADDR_W-1:0] prog_start_q, prog_end_q, data_start_q, data_end_q;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OFF_W-1:0]  off_q;
	logic [ADDR_W:0]   last_q;
	logic [ADDR_W-1:0] rel_q;
	logic              lo_ok_q;
	logic              mem_q;
	cmd_kind_t         single_kind_q;
	result_t           out_q, out_d;
	logic              out_valid_q;
	logic              out_load;
	logic              fire;
	logic              in_take;

	logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
	logic              alu_sub;
	logic              alu_ge;

	logic [STEP_W-1:0] cnt_w, step;
	cmd_kind_t         sel_kind;
	logic              is_last;
	logic              advance;

	assign in_take = s_axis_tvalid && s_axis_tready;
	assign fire    = !out_valid_q || m_axis_tready;

	// shared add/subtract unit
	assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	assign alu_ge  = !alu_res[ALU_W-1];

	// command choice for the current address and remaining count
	assign cnt_w = STEP_W'(cnt_q);
	always_comb begin
		if (addr_q[WORD_LG-1:0] != '0) begin
			sel_kind = CK_BYTE;
			step     = STEP_W'(1);
		end else if (addr_q[BLK_LG-1:0] != '0 && cnt_w >= STEP_W'(WORD_BYTES)) begin
			sel_kind = CK_WORD;
			step     = STEP_W'(WORD_BYTES);
		end else if (cnt_w >= STEP_W'(BLOCK_SIZE)) begin
			sel_kind = CK_BLOCK;
			step     = STEP_W'(BLOCK_SIZE);
		end else if (cnt_w >= STEP_W'(WORD_BYTES)) begin
			sel_kind = CK_WORD;
			step     = STEP_W'(WORD_BYTES);
		end else begin
			sel_kind = CK_BYTE;
			step     = STEP_W'(1);
		end
	end
	assign is_last = (cnt_w == step);

	always_comb begin
		state_d     = state_q;
		alu_a       = '0;
		alu_b       = '0;
		alu_sub     = 1'b0;
		out_load    = 1'b0;
		advance     = 1'b0;
		out_d.kind  = sel_kind;
		out_d.mem   = mem_q;
		out_d.target = addr_q;
		out_d.off   = off_q;
		out_d.last  = is_last;
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					state_d = (s_axis_tdata[31:24] == '0) ? S_SINGLE : S_LAST;
				end
			end
			S_LAST: begin
				alu_a   = ALU_W'(addr_q);
				alu_b   = ALU_W'(cnt_q - CNT_W'(1));
				state_d = (int'(cnt_q) > MAX_COUNT) ? S_SINGLE : S_PLO;
			end
			S_PLO: begin
				alu_a   = ALU_W'(addr_q);
				alu_b   = ALU_W'(prog_start_q);
				alu_sub = 1'b1;
				state_d = S_PHI;
			end
			S_PHI: begin
				alu_a   = ALU_W'(prog_end_q);
				alu_b   = ALU_W'(last_q);
				alu_sub = 1'b1;
				state_d = (lo_ok_q && alu_ge) ? S_EMIT : S_DLO;
			end
			S_DLO: begin
				alu_a   = ALU_W'(addr_q);
				alu_b   = ALU_W'(data_start_q);
				alu_sub = 1'b1;
				state_d = S_DHI;
			end
			S_DHI: begin
				alu_a   = ALU_W'(data_end_q);
				alu_b   = ALU_W'(last_q);
				alu_sub = 1'b1;
				state_d = (lo_ok_q && alu_ge) ? S_EMIT : S_SINGLE;
			end
			S_EMIT: begin
				alu_a = ALU_W'(addr_q);
				alu_b = ALU_W'(step);
				if (sel_kind == CK_BLOCK) begin
					state_d = S_REL;
				end else if (fire) begin
					out_load = 1'b1;
					advance  = 1'b1;
					if (is_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_REL: begin
				alu_a   = ALU_W'(addr_q);
				alu_b   = (mem_q == MEM_DATA) ? ALU_W'(data_start_q) : ALU_W'(prog_start_q);
				alu_sub = 1'b1;
				state_d = S_BLK;
			end
			S_BLK: begin
				alu_a        = ALU_W'(addr_q);
				alu_b        = ALU_W'(step);
				out_d.target = rel_q >> BLK_LG;
				if (fire) begin
					out_load = 1'b1;
					advance  = 1'b1;
					state_d  = is_last ? S_IDLE : S_EMIT;
				end
			end
			S_SINGLE: begin
				out_d.kind   = single_kind_q;
				out_d.mem    = MEM_PROG;
				out_d.off    = '0;
				out_d.last   = 1'b1;
				if (fire) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_start_q <= PROG_START_RST;
			prog_end_q   <= PROG_END_RST;
			data_start_q <= DATA_START_RST;
			data_end_q   <= DATA_END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROG_START: prog_start_q <= cfg_wdata;
				CFG_PROG_END:   prog_end_q   <= cfg_wdata;
				CFG_DATA_START: data_start_q <= cfg_wdata;
				CFG_DATA_END:   data_end_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					addr_q        <= s_axis_tdata[23:0];
					cnt_q         <= s_axis_tdata[31:24];
					off_q         <= '0;
					mem_q         <= MEM_PROG;
					single_kind_q <= CK_EMPTY;
				end
			end
			S_LAST: begin
				last_q <= alu_res[ADDR_W:0];
				if (int'(cnt_q) > MAX_COUNT) begin
					single_kind_q <= CK_REJECT;
				end
			end
			S_PLO, S_DLO: begin
				lo_ok_q <= alu_ge;
			end
			S_PHI: begin
				mem_q <= MEM_PROG;
			end
			S_DHI: begin
				mem_q <= MEM_DATA;
				if (!(lo_ok_q && alu_ge)) begin
					single_kind_q <= CK_REJECT;
				end
			end
			S_REL: begin
				rel_q <= alu_res[ADDR_W-1:0];
			end
			default: ;
		endcase
		if (advance) begin
			addr_q <= alu_res[ADDR_W-1:0];
			cnt_q  <= CNT_W'(cnt_w - step);
			off_q  <= off_q + OFF_W'(step);
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.off, out_q.target};
	assign m_axis_tuser  = {out_q.mem, out_q.kind};
	assign m_axis_tlast  = out_q.last;

	`FWCP_ASSERT_NEXT(a_busy_after_take, in_take, !s_axis_tready, "ready while request in work")
	`FWCP_ASSERT_NOW(a_emit_has_bytes, state_q == S_EMIT, cnt_q != '0, "emit with no bytes left")
	`FWCP_ASSERT_NOW(a_block_aligned, out_load && out_d.kind == CK_BLOCK, addr_q[BLK_LG-1:0] == '0, "block command on unaligned address")
	`FWCP_ASSERT_NEXT(a_run_continues, out_load && !out_d.last, state_q != S_IDLE, "request ended without last")

endmodule
